@@ rtl/core/rhp_pkg.sv @@
// Shared constants and types for the road height profile generator.
// No dependencies; imported by rhp_smooth, rhp_div, rhp_sine and the top.
`timescale 1ns / 1ps
package rhp_pkg;

    // Phase bits used by the sine evaluator (phase is truncated to these)
    localparam int SINE_TABLE_BITS = 10;

    // Odd Taylor coefficients of sin(pi/2*x), Q2.30
    localparam logic [31:0] COEF1 = 32'd1686629713;
    localparam logic [31:0] COEF3 = 32'd693598668;
    localparam logic [31:0] COEF5 = 32'd85569306;
    localparam logic [31:0] COEF7 = 32'd5026986;
    localparam logic [31:0] COEF9 = 32'd172271;

    localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

    // Quotient bits of the bump phase divider
    localparam int DIV_STAGES = 33;

    // Smoothstep saturates once the step offset reaches this many Q16.16 ticks
    localparam logic [31:0] SMOOTH_END = 32'd656;

    // Profile modes
    localparam logic [2:0] MODE_STEP     = 3'd0;
    localparam logic [2:0] MODE_SINE     = 3'd1;
    localparam logic [2:0] MODE_ROUGH    = 3'd2;
    localparam logic [2:0] MODE_BUMP     = 3'd3;
    localparam logic [2:0] MODE_COMPOUND = 3'd4;

    // Register indexes of the configuration port
    localparam logic [2:0] REG_MODE      = 3'd0;
    localparam logic [2:0] REG_AMPLITUDE = 3'd1;
    localparam logic [2:0] REG_FREQUENCY = 3'd2;
    localparam logic [2:0] REG_STEP_T0   = 3'd3;
    localparam logic [2:0] REG_STEP_H    = 3'd4;
    localparam logic [2:0] REG_BUMP_LEN  = 3'd5;
    localparam logic [2:0] REG_SPEED     = 3'd6;

    // One item in flight through the pipeline
    typedef struct packed {
        logic        valid;
        logic [31:0] t;        // time sample, signed Q16.16
        logic [62:0] tv;       // t * vehicle_speed
        logic        bump_ok;  // inside the bump window
        logic [31:0] phase;    // sine phase, Q0.32 cycles
        logic [31:0] smooth;   // smoothstep factor, Q1.30
        logic [31:0] sine;     // sine value, signed Q1.30
    } item_t;

endpackage

@@ rtl/core/rhp_smooth.sv @@
// Five-stage smoothstep pipeline: fills item.smooth from item.t.
// Depends on rhp_pkg.
`timescale 1ns / 1ps
module rhp_smooth
    import rhp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic [31:0] step_start,
    input  item_t       in_item,
    output item_t       out_item
);

    item_t       a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [32:0] d_off_reg;
    logic        neg_reg, big_reg, neg_b_reg, big_b_reg, neg_c_reg, big_c_reg;
    logic        neg_d_reg, big_d_reg;
    logic [29:0] tau_reg, tau_c_reg;
    logic [29:0] t2_reg, t2_d_reg;
    logic [29:0] t3_reg;

    logic [32:0] d_off_next;
    logic [16:0] d100;
    logic [59:0] t2_full, t3_full;
    logic [31:0] h_next;
    item_t       e_next;

    assign d_off_next = {in_item.t[31], in_item.t} - {step_start[31], step_start};
    assign d100       = 17'(d_off_reg[9:0]) * 17'd100;
    assign t2_full    = 60'(tau_reg) * 60'(tau_reg);
    assign t3_full    = 60'(t2_reg) * 60'(tau_c_reg);

    // h = 3*tau^2 - 2*tau^3, 0 before the step, 1.0 once past SMOOTH_END
    always_comb
    begin
        if (neg_d_reg)
            h_next = 32'd0;
        else if (big_d_reg)
            h_next = 32'(ONE_Q30);
        else
            h_next = 32'(t2_d_reg) * 32'd3 - 32'(t3_reg) * 32'd2;
    end

    // Last stage carries the item with its smoothstep factor filled in
    always_comb
    begin
        e_next        = d_reg;
        e_next.smooth = h_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg <= '0;
            b_reg <= '0;
            c_reg <= '0;
            d_reg <= '0;
            e_reg <= '0;
        end
        else if (en)
        begin
            a_reg <= in_item;
            b_reg <= a_reg;
            c_reg <= b_reg;
            d_reg <= c_reg;
            e_reg <= e_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_off_reg <= d_off_next;
            neg_reg   <= d_off_next[32];
            big_reg   <= !d_off_next[32] && (d_off_next[31:0] >= SMOOTH_END);
            tau_reg   <= {d100[15:0], 14'd0};
            neg_b_reg <= neg_reg;
            big_b_reg <= big_reg;
            t2_reg    <= t2_full[59:30];
            tau_c_reg <= tau_reg;
            neg_c_reg <= neg_b_reg;
            big_c_reg <= big_b_reg;
            t3_reg    <= t3_full[59:30];
            t2_d_reg  <= t2_reg;
            neg_d_reg <= neg_c_reg;
            big_d_reg <= big_c_reg;
        end
    end

    assign out_item = e_reg;

endmodule

@@ rtl/core/rhp_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, for the bump phase.
// Depends on rhp_pkg; replaces item.phase in bump mode.
`timescale 1ns / 1ps
module rhp_div
    import rhp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic [2:0]  mode,
    input  logic [31:0] bump_len,
    input  item_t       in_item,
    output item_t       out_item
);

    item_t       it_reg  [DIV_STAGES];
    logic [31:0] rem_reg [DIV_STAGES];
    logic [32:0] quo_reg [DIV_STAGES];

    genvar i;
    generate
        for (i = 0; i < DIV_STAGES; i++)
        begin : g_stage
            item_t       it_in;
            logic [31:0] rem_in;
            logic [32:0] quo_in;
            logic [32:0] dlow;
            logic [32:0] trial;
            logic        ge;

            if (i == 0)
            begin : g_first
                // remainder starts at (tv << 16) >> 33, below divisor if bump_ok
                assign it_in  = in_item;
                assign rem_in = in_item.tv[48:17];
                assign quo_in = '0;
            end
            else
            begin : g_next
                assign it_in  = it_reg[i-1];
                assign rem_in = rem_reg[i-1];
                assign quo_in = quo_reg[i-1];
            end

            assign dlow  = {it_in.tv[16:0], 16'd0};
            assign trial = {rem_in, dlow[DIV_STAGES-1-i]};
            assign ge    = trial >= {1'b0, bump_len};

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    it_reg[i] <= '0;
                else if (en)
                    it_reg[i] <= it_in;
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[i] <= ge ? 32'(trial - {1'b0, bump_len}) : trial[31:0];
                    quo_reg[i] <= {quo_in[31:0], ge};
                end
            end
        end
    endgenerate

    // Bump phase is the quotient over four: a quarter cycle spans the window
    always_comb
    begin
        out_item = it_reg[DIV_STAGES-1];
        if (mode == MODE_BUMP)
            out_item.phase = {1'b0, quo_reg[DIV_STAGES-1][32:2]};
    end

endmodule

@@ rtl/core/rhp_sine.sv @@
// Seven-stage sine evaluator: quadrant fold and Horner polynomial on x^2.
// Depends on rhp_pkg; fills item.sine from item.phase.
`timescale 1ns / 1ps
module rhp_sine
    import rhp_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  en,
    input  item_t in_item,
    output item_t out_item
);

    localparam int RB = SINE_TABLE_BITS - 2;

    item_t       it_reg [7];
    logic [1:0]  quad_reg [6];
    logic [30:0] x_reg [6];
    logic [30:0] x2_reg [5];
    logic [31:0] p_reg [4];
    logic [31:0] s_reg;

    logic [SINE_TABLE_BITS-1:0] k;
    logic [RB-1:0]              r;
    logic [30:0]                x_raw, x_next;
    logic [61:0]                x2_full;
    logic [62:0]                px_full;
    logic [31:0]                mag;

    // one Horner step: c - floor(p * x2 / 2^30)
    function automatic logic [31:0] horner(input logic [31:0] c, input logic [31:0] p,
                                           input logic [30:0] x2);
        logic [62:0] prod;
        begin
            prod   = 63'(p) * 63'(x2);
            horner = c - prod[61:30];
        end
    endfunction

    assign k       = in_item.phase[31 -: SINE_TABLE_BITS];
    assign r       = k[RB-1:0];
    assign x_raw   = 31'(r) << (32 - SINE_TABLE_BITS);
    assign x_next  = k[RB] ? ONE_Q30 - x_raw : x_raw;
    assign x2_full = 62'(x_reg[0]) * 62'(x_reg[0]);
    assign px_full = 63'(p_reg[3]) * 63'(x_reg[5]);
    assign mag     = (px_full[62:30] > 33'(ONE_Q30)) ? 32'(ONE_Q30) : px_full[61:30];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < 7; j++)
                it_reg[j] <= '0;
        end
        else if (en)
        begin
            it_reg[0] <= in_item;
            for (int j = 1; j < 7; j++)
                it_reg[j] <= it_reg[j-1];
        end
    end

    // Datapath: fold, x^2, four Horner steps, final multiply and sign
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quad_reg[0] <= k[SINE_TABLE_BITS-1 -: 2];
            x_reg[0]    <= x_next;
            for (int j = 1; j < 6; j++)
            begin
                quad_reg[j] <= quad_reg[j-1];
                x_reg[j]    <= x_reg[j-1];
            end
            x2_reg[0] <= x2_full[60:30];
            for (int j = 1; j < 5; j++)
                x2_reg[j] <= x2_reg[j-1];
            p_reg[0] <= horner(COEF7, COEF9, x2_reg[0]);
            p_reg[1] <= horner(COEF5, p_reg[0], x2_reg[1]);
            p_reg[2] <= horner(COEF3, p_reg[1], x2_reg[2]);
            p_reg[3] <= horner(COEF1, p_reg[2], x2_reg[3]);
            s_reg    <= quad_reg[5][1] ? 32'd0 - mag : mag;
        end
    end

    always_comb
    begin
        out_item      = it_reg[6];
        out_item.sine = s_reg;
    end

endmodule

@@ rtl/core/road_height_profile_generator_top.sv @@
// Top level of the road height profile generator: config registers, input
// stage, output scaling and saturation. Uses rhp_pkg, rhp_smooth, rhp_div, rhp_sine.
//
//  channel   | direction | payload
//  ----------+-----------+------------------------------------------------
//  s_axis    | in        | tdata[31:0] time_sample
//  m_axis    | out       | tdata[31:0] road_height, tuser[0] saturated
//  cfg       | in        | cfg_index selects register, cfg_data value
//
// One item per clock unless the output stalls; most of the pipeline from accept
// to result is the 33-stage bump phase divider.
// Reset clears the config registers to their defaults and all valid bits.
// A stalled result freezes the whole pipeline; nothing is lost or repeated.
`timescale 1ns / 1ps
module road_height_profile_generator_top
    import rhp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] time_sample
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] road_height
    output logic        m_axis_tuser,   // [0] saturated
    input  logic        cfg_wen,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    logic [2:0]  mode_reg;
    logic [31:0] amplitude_reg, frequency_reg, step_start_reg, step_height_reg;
    logic [31:0] bump_len_reg, speed_reg;

    logic        en;
    item_t       in_next, s1_reg, smooth_out, div_out, sine_out;
    item_t       f1_reg, f2_reg;
    logic signed [64:0] fprod;
    logic [62:0] tv_next;
    logic [31:0] sq_reg;
    logic signed [63:0] sq_full;
    logic signed [63:0] pa_reg, pb_reg;
    logic signed [31:0] fac, amp_b;
    logic signed [33:0] ra, rb;
    logic signed [34:0] h;
    logic        m_valid_reg, sat_reg;
    logic [31:0] height_reg;

    // Config register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= MODE_STEP;
            amplitude_reg   <= 32'd26843546;
            frequency_reg   <= 32'd21810381;
            step_start_reg  <= 32'd32768;
            step_height_reg <= 32'd16106127;
            bump_len_reg    <= 32'd8388608;
            speed_reg       <= 32'd139754209;
        end
        else if (cfg_wen)
        begin
            case (cfg_index)
                REG_MODE:      mode_reg        <= cfg_data[2:0];
                REG_AMPLITUDE: amplitude_reg   <= cfg_data;
                REG_FREQUENCY: frequency_reg   <= cfg_data;
                REG_STEP_T0:   step_start_reg  <= cfg_data;
                REG_STEP_H:    step_height_reg <= cfg_data;
                REG_BUMP_LEN:  bump_len_reg    <= cfg_data;
                REG_SPEED:     speed_reg       <= cfg_data;
                default:       ;
            endcase
        end
    end

    // Whole pipeline advances unless a result is held at the output
    assign en            = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = en;

    // Input stage: sine phase product and bump window test
    assign fprod   = $signed({1'b0, frequency_reg}) * $signed(s_axis_tdata);
    assign tv_next = 63'(s_axis_tdata[30:0]) * 63'(speed_reg);

    always_comb
    begin
        in_next         = '0;
        in_next.valid   = s_axis_tvalid;
        in_next.t       = s_axis_tdata;
        in_next.tv      = tv_next;
        in_next.bump_ok = (speed_reg != 32'd0) && (bump_len_reg != 32'd0)
                          && !s_axis_tdata[31]
                          && (tv_next <= {15'd0, bump_len_reg, 16'd0});
        in_next.phase   = fprod[39:8];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_reg <= '0;
        else if (en)
            s1_reg <= in_next;
    end

    rhp_smooth u_smooth (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .step_start (step_start_reg),
        .in_item    (s1_reg),
        .out_item   (smooth_out)
    );

    rhp_div u_div (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .mode        (mode_reg),
        .bump_len    (bump_len_reg),
        .in_item     (smooth_out),
        .out_item    (div_out)
    );

    rhp_sine u_sine (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_item  (div_out),
        .out_item (sine_out)
    );

    // Squared sine for the bump versine
    assign sq_full = $signed(sine_out.sine) * $signed(sine_out.sine);

    // Factor and amplitude selection for the two scaling products
    assign fac   = (mode_reg == MODE_BUMP) ? $signed(sq_reg) : $signed(f1_reg.sine);
    assign amp_b = (mode_reg == MODE_STEP) ? $signed(amplitude_reg)
                                           : $signed(step_height_reg);

    // Round to nearest, ties up, then combine by mode
    assign ra = 34'((pa_reg + 64'sd536870912) >>> 30);
    assign rb = 34'((pb_reg + 64'sd536870912) >>> 30);

    always_comb
    begin
        case (mode_reg)
            MODE_STEP:     h = 35'(rb);
            MODE_SINE,
            MODE_ROUGH:    h = 35'(ra);
            MODE_BUMP:     h = f2_reg.bump_ok ? 35'(ra) : 35'sd0;
            MODE_COMPOUND: h = 35'(ra) + 35'(rb);
            default:       h = 35'sd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_reg      <= '0;
            f2_reg      <= '0;
            m_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            f1_reg      <= sine_out;
            f2_reg      <= f1_reg;
            m_valid_reg <= f2_reg.valid;
        end
    end

    // Scaling datapath and saturating output register
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_reg <= sq_full[61:30];
            pa_reg <= $signed(amplitude_reg) * fac;
            pb_reg <= amp_b * $signed(f1_reg.smooth);
            if (h > 35'sh7FFF_FFFF)
            begin
                height_reg <= 32'h7FFF_FFFF;
                sat_reg    <= 1'b1;
            end
            else if (h < -35'sh8000_0000)
            begin
                height_reg <= 32'h8000_0000;
                sat_reg    <= 1'b1;
            end
            else
            begin
                height_reg <= h[31:0];
                sat_reg    <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = height_reg;
    assign m_axis_tuser  = sat_reg;

endmodule

@@ rtl/core/rhp_checker.sv @@
// Port-level checks for the road height profile generator, bound to the top.
// Depends on road_height_profile_generator_top.
`timescale 1ns / 1ps
module rhp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic        m_axis_tuser
);

    // No result right after a reset edge
    a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !m_axis_tvalid)
        else $error("result valid during reset");

    // Input side is ready exactly when the output can move
    a_ready_link: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("input ready does not follow output state");

    // A clipped height sits at one of the range limits
    a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |->
        (m_axis_tdata == 32'h7FFF_FFFF || m_axis_tdata == 32'h8000_0000))
        else $error("saturated flag with unclipped height");

    // Stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
        (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled result changed");

endmodule

bind road_height_profile_generator_top rhp_checker u_rhp_checker (.*);
